// ----- rtl/ihsv_pkg.sv -----
// Shared types, codes and helper functions for the Intel HEX stream validator.
// No dependencies; compile first.
package ihsv_pkg;

   localparam int LIMIT_W   = 17;
   localparam int LEN_CMP_W = 10;   // holds twice the longest record plus two

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_TYPE  = 8'h43;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_EOF  = 8'h01;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h01E00;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_LINE = 2'd1,
      KIND_FILE = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_OK            = 4'd0,
      ST_BAD_HEADER    = 4'd1,
      ST_SHORT         = 4'd2,
      ST_NO_TYPE       = 4'd3,
      ST_NOT_MONOTONIC = 4'd4,
      ST_LIMIT         = 4'd5,
      ST_BAD_TYPE      = 4'd6,
      ST_BAD_LINE      = 4'd7,
      ST_TYPE_MISSING  = 4'd8
   } status_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         data_byte;
      logic [LIMIT_W-1:0] byte_address;
      logic [7:0]         record_type;
      logic [3:0]         status;
      logic               last;
   } rsp_entry_type;

   // Digit value as the file computes it, kept modulo 256
   function automatic logic [7:0] digit_formula(input logic [7:0] c);
      if (c <= 8'h39) begin
         return c - 8'h30;
      end
      return 8'd10 + (c | 8'h20) - 8'h61;
   endfunction

   function automatic logic is_hex_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
   endfunction

endpackage

// ----- rtl/ihsv_req_if.sv -----
// Input channel of the validator: one file character or end of file per word.
// No dependencies; uses plain widths only.
interface ihsv_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] char_code;

   modport source (output valid, output operation, output char_code, input ready);
   modport sink   (input valid, input operation, input char_code, output ready);
endinterface

// ----- rtl/ihsv_rsp_if.sv -----
// Result channel of the validator: data bytes, line verdicts, file verdicts.
// Depends on ihsv_pkg for the address width.
interface ihsv_rsp_if;
   import ihsv_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [7:0]         data_byte;
   logic [LIMIT_W-1:0] byte_address;
   logic [7:0]         record_type;
   logic [3:0]         status;
   logic               last;

   modport source (output valid, output kind, output data_byte, output byte_address,
                   output record_type, output status, output last, input ready);
   modport sink   (input valid, input kind, input data_byte, input byte_address,
                   input record_type, input status, input last, output ready);
endinterface

// ----- rtl/intel_hex_stream_validator.sv -----
// Intel HEX firmware stream validator: top level, parser state and result queue.
// Depends on ihsv_pkg, ihsv_req_if and ihsv_rsp_if.

// The block takes a firmware text file one character per word on req_ch and
// accepts a new word every clock cycle while req_ch.ready is high: each
// character updates the line parser registers and its results land in a
// four-entry result queue that drains on rsp_ch at one word per cycle while
// rsp_ch.ready is high. A character gives at most one result; an end-of-file
// word with a line still open gives two (line verdict, then file verdict), so
// req_ch.ready needs room for two results in the queue. With rsp_ch always
// ready the sustained rate is one word per cycle; throughput drops only if the
// consumer stalls or end-of-file words come back to back faster than the queue
// drains. data_limit (csr_write_data) takes effect at the edge where
// csr_write_enable is high and should only change between files. No
// initialization pass is needed after reset.
module intel_hex_stream_validator #(
   parameter int MAX_LINE = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   ihsv_req_if.sink                     req_ch,
   ihsv_rsp_if.source                   rsp_ch,
   input  logic                         csr_write_enable,
   input  logic [ihsv_pkg::LIMIT_W-1:0] csr_write_data
);
   import ihsv_pkg::*;

   localparam int POS_W      = $clog2(MAX_LINE);
   localparam int CMP_W      = (POS_W > LEN_CMP_W) ? POS_W : LEN_CMP_W;
   localparam int HDR_CHARS  = 9;   // ':' plus eight header digits
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);

   typedef enum logic [2:0] {
      LK_START,
      LK_COMMENT,
      LK_TYPE,
      LK_RECORD,
      LK_BAD_HEADER,
      LK_BAD_LINE,
      LK_NO_TYPE
   } line_kind_type;

   // parser state
   line_kind_type      line_kind_ff, line_kind_in;
   logic [POS_W-1:0]   char_position_ff, char_position_in;
   logic [3:0]         nibble_hold_ff, nibble_hold_in;
   logic [7:0]         record_length_ff, record_length_in;
   logic [15:0]        record_address_ff, record_address_in;
   logic [7:0]         type_code_ff, type_code_in;
   logic [15:0]        last_data_offset_ff, last_data_offset_in;
   logic               type_seen_ff, type_seen_in;
   logic               failed_ff, failed_in;
   logic [LIMIT_W-1:0] data_limit_ff, data_limit_in;

   // result queue
   rsp_entry_type      fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               accept;
   logic               pop;
   logic [1:0]         n_results;
   rsp_entry_type      res0, res1;

   // line verdict of the current line
   status_type         line_status;
   logic               line_ldo_update;
   logic [7:0]         line_rtype;
   logic [CMP_W-1:0]   tail_chars;
   logic [CMP_W-1:0]   tail_needed;
   logic [LIMIT_W-1:0] record_end;
   logic               addr_monotonic;
   logic               addr_in_limit;

   // data character decode
   logic [POS_W-1:0]   data_index;
   logic [CMP_W-1:0]   byte_index;
   logic [7:0]         digit_value;
   logic               data_enable;

   assign accept = req_ch.valid && req_ch.ready;
   assign pop    = rsp_ch.valid && rsp_ch.ready;

   assign req_ch.ready = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign rsp_ch.valid = (count_ff != '0);

   assign rsp_ch.kind         = fifo_ff[rd_ptr_ff].kind;
   assign rsp_ch.data_byte    = fifo_ff[rd_ptr_ff].data_byte;
   assign rsp_ch.byte_address = fifo_ff[rd_ptr_ff].byte_address;
   assign rsp_ch.record_type  = fifo_ff[rd_ptr_ff].record_type;
   assign rsp_ch.status       = fifo_ff[rd_ptr_ff].status;
   assign rsp_ch.last         = fifo_ff[rd_ptr_ff].last;

   // shared header/range checks
   assign tail_chars     = CMP_W'(char_position_ff) - CMP_W'(HDR_CHARS);
   assign tail_needed    = CMP_W'({record_length_ff, 1'b0}) + CMP_W'(2);
   assign record_end     = LIMIT_W'(record_address_ff) + LIMIT_W'(record_length_ff);
   assign addr_monotonic = (record_address_ff >= last_data_offset_ff);
   assign addr_in_limit  = (record_end <= data_limit_ff);

   assign data_index  = char_position_ff - POS_W'(HDR_CHARS);
   assign byte_index  = CMP_W'(data_index >> 1);
   assign digit_value = digit_formula(req_ch.char_code);
   assign data_enable = (line_kind_ff == LK_RECORD) && (type_code_ff == REC_DATA) &&
                        addr_monotonic && addr_in_limit;

   // verdict for the line now open
   always_comb begin
      line_status     = ST_OK;
      line_ldo_update = 1'b0;
      line_rtype      = ((line_kind_ff == LK_RECORD) || (line_kind_ff == LK_BAD_HEADER)) ?
                        type_code_ff : 8'h00;
      case (line_kind_ff)
         LK_COMMENT, LK_TYPE: begin
            line_status = ST_OK;
         end
         LK_NO_TYPE: begin
            line_status = ST_NO_TYPE;
         end
         LK_BAD_HEADER: begin
            line_status = ST_BAD_HEADER;
         end
         LK_RECORD: begin
            if (char_position_ff < POS_W'(HDR_CHARS)) begin
               line_status = ST_BAD_HEADER;
            end else if (type_code_ff == REC_DATA) begin
               if (tail_chars < tail_needed) begin
                  line_status = ST_SHORT;
               end else if (!addr_monotonic) begin
                  line_status = ST_NOT_MONOTONIC;
               end else if (!addr_in_limit) begin
                  line_status = ST_LIMIT;
               end else begin
                  line_ldo_update = 1'b1;
               end
            end else if (type_code_ff != REC_EOF) begin
               line_status = ST_BAD_TYPE;
            end
         end
         default: begin
            // empty or overlong line, or unknown first character
            line_status = ST_BAD_LINE;
         end
      endcase
   end

   // next parser state and results for the accepted word
   always_comb begin
      line_kind_in        = line_kind_ff;
      char_position_in    = char_position_ff;
      nibble_hold_in      = nibble_hold_ff;
      record_length_in    = record_length_ff;
      record_address_in   = record_address_ff;
      type_code_in        = type_code_ff;
      last_data_offset_in = last_data_offset_ff;
      type_seen_in        = type_seen_ff;
      failed_in           = failed_ff;
      data_limit_in       = csr_write_enable ? csr_write_data : data_limit_ff;
      n_results           = 2'd0;
      res0                = '0;
      res1                = '0;

      if (accept) begin
         if (!req_ch.operation) begin
            if (!failed_ff && (req_ch.char_code != CH_CR)) begin
               if (req_ch.char_code == CH_LF) begin
                  // line end: verdict, then back to start of line
                  res0.kind        = KIND_LINE;
                  res0.record_type = line_rtype;
                  res0.status      = line_status;
                  res0.last        = 1'b1;
                  n_results        = 2'd1;
                  if (line_status != ST_OK) begin
                     failed_in      = 1'b1;
                     nibble_hold_in = line_status;
                  end
                  if (line_ldo_update) begin
                     last_data_offset_in = record_address_ff;
                  end
                  line_kind_in     = LK_START;
                  char_position_in = '0;
                  type_code_in     = 8'h00;
               end else if (char_position_ff >= POS_LAST) begin
                  line_kind_in = LK_BAD_LINE;
               end else begin
                  char_position_in = char_position_ff + POS_W'(1);
                  if (char_position_ff == '0) begin
                     case (req_ch.char_code)
                        CH_HASH: begin
                           line_kind_in = LK_COMMENT;
                        end
                        CH_TYPE: begin
                           line_kind_in = LK_TYPE;
                           type_seen_in = 1'b1;
                        end
                        CH_COLON: begin
                           line_kind_in      = type_seen_ff ? LK_RECORD : LK_NO_TYPE;
                           record_length_in  = 8'h00;
                           record_address_in = 16'h0000;
                           type_code_in      = 8'h00;
                        end
                        default: begin
                           line_kind_in = LK_BAD_LINE;
                        end
                     endcase
                  end else if (line_kind_ff == LK_RECORD) begin
                     if (char_position_ff < POS_W'(HDR_CHARS)) begin
                        // header digits: length 1..2, address 3..6, type 7..8
                        if (!is_hex_digit(req_ch.char_code)) begin
                           line_kind_in = LK_BAD_HEADER;
                        end else if (char_position_ff <= POS_W'(2)) begin
                           record_length_in = {record_length_ff[3:0], digit_value[3:0]};
                        end else if (char_position_ff <= POS_W'(6)) begin
                           record_address_in = {record_address_ff[11:0], digit_value[3:0]};
                        end else begin
                           type_code_in = {type_code_ff[3:0], digit_value[3:0]};
                        end
                     end else if (data_enable) begin
                        if (!data_index[0]) begin
                           nibble_hold_in = digit_value[3:0];
                        end else if (byte_index < CMP_W'(record_length_ff)) begin
                           res0.kind         = KIND_DATA;
                           res0.data_byte    = {nibble_hold_ff, 4'h0} | digit_value;
                           res0.byte_address = LIMIT_W'(record_address_ff) +
                                               LIMIT_W'(byte_index);
                           res0.record_type  = type_code_ff;
                           res0.status       = ST_OK;
                           res0.last         = 1'b1;
                           n_results         = 2'd1;
                        end
                     end
                  end
               end
            end
         end else begin
            // end of file: close an open line, then the file verdict
            rsp_entry_type file_res;
            file_res      = '0;
            file_res.kind = KIND_FILE;
            file_res.last = 1'b1;
            if (failed_ff) begin
               file_res.status = nibble_hold_ff;
            end else if ((line_kind_ff != LK_START) && (line_status != ST_OK)) begin
               file_res.status = line_status;
            end else if (!type_seen_ff) begin
               file_res.status = ST_TYPE_MISSING;
            end else begin
               file_res.status = ST_OK;
            end
            if (!failed_ff && (line_kind_ff != LK_START)) begin
               res0.kind        = KIND_LINE;
               res0.record_type = line_rtype;
               res0.status      = line_status;
               res0.last        = 1'b0;
               res1             = file_res;
               n_results        = 2'd2;
            end else begin
               res0      = file_res;
               n_results = 2'd1;
            end
            line_kind_in        = LK_START;
            char_position_in    = '0;
            nibble_hold_in      = 4'h0;
            record_length_in    = 8'h00;
            record_address_in   = 16'h0000;
            type_code_in        = 8'h00;
            last_data_offset_in = 16'h0000;
            type_seen_in        = 1'b0;
            failed_in           = 1'b0;
         end
      end

      wr_ptr_in = wr_ptr_ff + PTR_W'(n_results);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(n_results) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_kind_ff        <= LK_START;
         char_position_ff    <= '0;
         nibble_hold_ff      <= 4'h0;
         record_length_ff    <= 8'h00;
         record_address_ff   <= 16'h0000;
         type_code_ff        <= 8'h00;
         last_data_offset_ff <= 16'h0000;
         type_seen_ff        <= 1'b0;
         failed_ff           <= 1'b0;
         data_limit_ff       <= LIMIT_RESET;
         wr_ptr_ff           <= '0;
         rd_ptr_ff           <= '0;
         count_ff            <= '0;
      end else begin
         line_kind_ff        <= line_kind_in;
         char_position_ff    <= char_position_in;
         nibble_hold_ff      <= nibble_hold_in;
         record_length_ff    <= record_length_in;
         record_address_ff   <= record_address_in;
         type_code_ff        <= type_code_in;
         last_data_offset_ff <= last_data_offset_in;
         type_seen_ff        <= type_seen_in;
         failed_ff           <= failed_in;
         data_limit_ff       <= data_limit_in;
         wr_ptr_ff           <= wr_ptr_in;
         rd_ptr_ff           <= rd_ptr_in;
         count_ff            <= count_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (n_results != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (n_results == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Testbench for intel_hex_stream_validator: random firmware text files in, results checked.
// Depends on ihsv_pkg, ihsv_req_if, ihsv_rsp_if and the validator RTL.
module tb;
   import ihsv_pkg::*;

   localparam int MAX_LINE   = 256;
   localparam int WAIT_MAX   = 13;
   localparam int ITEM_GOAL  = 700;
   localparam int PHASE_SIZE = 140;

   // line classes of the parser, mostly decided by the first character
   typedef enum logic [2:0] {
      LK_START, LK_COMMENT, LK_TYPE, LK_RECORD, LK_BADHDR, LK_BADLINE, LK_NOTYPE
   } line_state_type;

   // ways a random file gets broken
   typedef enum int {
      F_HEADER, F_SHORT, F_BACK, F_LIMIT, F_TYPE, F_FIRST, F_EMPTY, F_LONG, F_NOTYPE, F_NOISE
   } fault_type;

   typedef struct packed {
      logic       eof;
      logic [7:0] ch;
   } file_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                csr_write_enable = 1'b0;
   logic [LIMIT_W-1:0]  csr_write_data   = '0;

   ihsv_req_if req_ch ();
   ihsv_rsp_if rsp_ch ();

   intel_hex_stream_validator #(.MAX_LINE(MAX_LINE)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Parser state as the testbench tracks it, plus the data_limit copy
   // ---------------------------------------------------------------------------
   logic [LIMIT_W-1:0] limit_copy = LIMIT_RESET;
   line_state_type     line_kind  = LK_START;
   int                 char_pos   = 0;
   logic [3:0]         hold_nib   = '0;   // high nibble of a data byte, later the first error
   logic [7:0]         rec_len    = '0;
   logic [15:0]        rec_addr   = '0;
   logic [7:0]         rec_type   = '0;
   logic [15:0]        last_offset = '0;
   bit                 type_seen  = 1'b0;
   bit                 failed     = 1'b0;

   file_word_type file_words[$];      // words waiting to be sent
   rsp_entry_type expected_words[$];  // results owed by the block, oldest first

   int error_count  = 0;
   int useful_words = 0;   // accepted words the parser did not simply drop
   int pushed_words = 0;
   int data_seen = 0, line_seen = 0, file_seen = 0;
   int files_sent = 0, limits_used = 1;

   int feed_gap = 0, drain_stall = 0;
   bit feed_calm = 1'b0, drain_calm = 1'b1;

   function automatic rsp_entry_type make_word(kind_type k, logic [7:0] b,
                                               logic [LIMIT_W-1:0] a, logic [7:0] rt,
                                               status_type st);
      rsp_entry_type w;
      w.kind         = k;
      w.data_byte    = b;
      w.byte_address = a;
      w.record_type  = rt;
      w.status       = st;
      w.last         = 1'b0;
      return w;
   endfunction

   function automatic int pick_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, WAIT_MAX);
   endfunction

   // Line end: verdict for the line just closed; an error sticks until end of file
   task automatic close_line(output rsp_entry_type verdict);
      status_type st;
      logic [7:0] rt;
      st = ST_OK;
      rt = (line_kind == LK_RECORD || line_kind == LK_BADHDR) ? rec_type : 8'h00;
      case (line_kind)
         LK_COMMENT, LK_TYPE: st = ST_OK;
         LK_NOTYPE:           st = ST_NO_TYPE;
         LK_BADHDR:           st = ST_BAD_HEADER;
         LK_RECORD: begin
            if (char_pos < 9) begin
               st = ST_BAD_HEADER;
            end else if (rec_type == REC_DATA) begin
               // length counted without wrap, so one or zero body chars is short
               if (char_pos - 9 < 2 * int'(rec_len) + 2) st = ST_SHORT;
               else if (rec_addr < last_offset) st = ST_NOT_MONOTONIC;
               else if (int'(rec_addr) + int'(rec_len) > int'(limit_copy)) st = ST_LIMIT;
               else last_offset = rec_addr;
            end else if (rec_type != REC_EOF) begin
               st = ST_BAD_TYPE;
            end
         end
         default: st = ST_BAD_LINE;   // empty, overlong or unknown first char
      endcase
      verdict = make_word(KIND_LINE, 8'h00, '0, rt, st);
      if (st != ST_OK) begin
         failed   = 1'b1;
         hold_nib = st;
      end
      line_kind = LK_START;
      char_pos  = 0;
      rec_type  = 8'h00;
   endtask

   // Works out the results of one accepted word and queues them
   task automatic predict_validation(input logic eof, input logic [7:0] c, output bit dropped);
      rsp_entry_type outs[2];
      int            n, p, q, ia;
      logic [7:0]    dv;
      logic [3:0]    hv;
      bit            is_hex;
      n       = 0;
      dropped = 1'b0;
      if (!eof) begin
         if (failed || c == CH_CR) begin
            dropped = 1'b1;
         end else if (c == CH_LF) begin
            close_line(outs[0]);
            n = 1;
         end else if (char_pos >= MAX_LINE - 1) begin
            line_kind = LK_BADLINE;
         end else begin
            p = char_pos;
            char_pos++;
            if (p == 0) begin
               if (c == CH_HASH) begin
                  line_kind = LK_COMMENT;
               end else if (c == CH_TYPE) begin
                  line_kind = LK_TYPE;
                  type_seen = 1'b1;
               end else if (c == CH_COLON) begin
                  line_kind = type_seen ? LK_RECORD : LK_NOTYPE;
                  rec_len   = 8'h00;
                  rec_addr  = 16'h0000;
                  rec_type  = 8'h00;
               end else begin
                  line_kind = LK_BADLINE;
               end
            end else if (line_kind == LK_RECORD) begin
               if (p <= 8) begin
                  is_hex = 1'b1;
                  if (c >= 8'h30 && c <= 8'h39) hv = c[3:0];
                  else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                     hv = c[3:0] + 4'd9;
                  else is_hex = 1'b0;
                  if (!is_hex) line_kind = LK_BADHDR;
                  else if (p <= 2) rec_len = {rec_len[3:0], hv};
                  else if (p <= 6) rec_addr = {rec_addr[11:0], hv};
                  else rec_type = {rec_type[3:0], hv};
               end else if (rec_type == REC_DATA && rec_addr >= last_offset &&
                            int'(rec_addr) + int'(rec_len) <= int'(limit_copy)) begin
                  // digit value taken the file's way, not validated, modulo 256
                  q  = p - 9;
                  dv = (c <= 8'h39) ? c - 8'h30 : 8'd10 + (c | 8'h20) - 8'h61;
                  if (q % 2 == 0) begin
                     hold_nib = dv[3:0];
                  end else if (q / 2 < int'(rec_len)) begin
                     ia = int'(rec_addr) + q / 2;
                     outs[0] = make_word(KIND_DATA, {hold_nib, 4'h0} | dv, ia[LIMIT_W-1:0],
                                         rec_type, ST_OK);
                     n = 1;
                  end
               end
            end
         end
      end else begin
         if (!failed && line_kind != LK_START) begin
            close_line(outs[0]);
            n = 1;
         end
         outs[n] = make_word(KIND_FILE, 8'h00, '0, 8'h00,
                             failed ? status_type'(hold_nib) :
                             (!type_seen ? ST_TYPE_MISSING : ST_OK));
         n++;
         line_kind   = LK_START;
         char_pos    = 0;
         hold_nib    = '0;
         rec_len     = '0;
         rec_addr    = '0;
         rec_type    = '0;
         last_offset = '0;
         type_seen   = 1'b0;
         failed      = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
         outs[i].last = (i == n - 1);
         expected_words.push_back(outs[i]);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Driver: one word per handshake, random gap drawn per word
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      file_word_type w;
      bit            dropped;
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.operation <= 1'b0;
         req_ch.char_code <= 8'h00;
         feed_gap = pick_wait(feed_calm);
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_validation(req_ch.operation, req_ch.char_code, dropped);
            if (!dropped) useful_words++;
         end
         // a word that is offered but not yet taken stays as it is
         if (!req_ch.valid || req_ch.ready) begin
            if (feed_gap > 0) begin
               feed_gap--;
               req_ch.valid <= 1'b0;
            end else if (file_words.size() > 0) begin
               w = file_words.pop_front();
               req_ch.valid     <= 1'b1;
               req_ch.operation <= w.eof;
               req_ch.char_code <= w.ch;
               if ($urandom_range(0, 49) == 0) feed_calm = !feed_calm;
               feed_gap = pick_wait(feed_calm);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: takes results with random back-pressure, checks each field
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_entry_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         drain_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind         = rsp_ch.kind;
            got.data_byte    = rsp_ch.data_byte;
            got.byte_address = rsp_ch.byte_address;
            got.record_type  = rsp_ch.record_type;
            got.status       = rsp_ch.status;
            got.last         = rsp_ch.last;
            if (expected_words.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $write("%0t: unexpected word kind %0d byte %02h addr %05h",
                         $realtime, got.kind, got.data_byte, got.byte_address);
                  $display(" type %02h st %0d last %0d",
                           got.record_type, got.status, got.last);
               end
            end else begin
               want = expected_words.pop_front();
               case (want.kind)
                  KIND_DATA: data_seen++;
                  KIND_LINE: line_seen++;
                  default:   file_seen++;
               endcase
               if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                   got.byte_address !== want.byte_address ||
                   got.record_type !== want.record_type ||
                   got.status !== want.status || got.last !== want.last) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $write("%0t: mismatch exp kind %0d byte %02h addr %05h",
                            $realtime, want.kind, want.data_byte, want.byte_address);
                     $write(" type %02h st %0d last %0d,",
                            want.record_type, want.status, want.last);
                     $write(" got kind %0d byte %02h addr %05h",
                            got.kind, got.data_byte, got.byte_address);
                     $display(" type %02h st %0d last %0d",
                              got.record_type, got.status, got.last);
                  end
               end
            end
            if ($urandom_range(0, 49) == 0) drain_calm = !drain_calm;
            drain_stall = pick_wait(drain_calm);
         end
         if (drain_stall > 0) begin
            drain_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // File text builders; all pushes happen at the falling edge
   // ---------------------------------------------------------------------------
   task automatic push_char(input logic [7:0] c);
      file_word_type w;
      w.eof = 1'b0;
      w.ch  = c;
      file_words.push_back(w);
      pushed_words++;
   endtask

   // char_code is don't-care on end of file, so it carries noise
   task automatic push_eof();
      file_word_type w;
      w.eof = 1'b1;
      w.ch  = 8'($urandom_range(0, 255));
      file_words.push_back(w);
      pushed_words++;
      files_sent++;
   endtask

   function automatic logic [7:0] any_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
      return c;
   endfunction

   task automatic push_nibble(input logic [3:0] n);
      if (n < 4'd10) push_char({4'h0, n} + 8'h30);
      else push_char({4'h0, n} - 8'd10 + ($urandom_range(0, 1) ? 8'h41 : 8'h61));
   endtask

   task automatic push_hex(input logic [7:0] v);
      push_nibble(v[7:4]);
      push_nibble(v[3:0]);
   endtask

   task automatic push_eol();
      if ($urandom_range(0, 3) == 0) push_char(CH_CR);
      push_char(CH_LF);
   endtask

   // record with a chosen number of body chars (data plus checksum)
   task automatic put_record(input int len, input int addr, input logic [7:0] rtype,
                             input int body, input bit messy, input bit eol);
      push_char(CH_COLON);
      push_hex(len[7:0]);
      push_hex(addr[15:8]);
      push_hex(addr[7:0]);
      push_hex(rtype);
      for (int i = 0; i < body; i++) begin
         if (messy && $urandom_range(0, 3) == 0) push_char(any_char());
         else push_nibble(4'($urandom_range(0, 15)));
      end
      if (eol) push_eol();
   endtask

   // data record that passes: rising address, ends at or below the limit
   task automatic put_good_record(inout int last, input bit eol);
      int len, room, hi, addr, r;
      r = $urandom_range(0, 9);
      len  = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 16) : $urandom_range(17, 60);
      room = int'(limit_copy) - last;
      if (len > room) len = room;
      hi = int'(limit_copy) - len;
      if (hi > 65535) hi = 65535;
      case ($urandom_range(0, 7))
         0:       addr = hi;                      // flush against the limit
         1, 2, 3: addr = last + $urandom_range(0, (hi - last < 32) ? hi - last : 32);
         default: addr = $urandom_range(last, hi);
      endcase
      last = addr;
      put_record(len, addr, REC_DATA, 2 * len + 2, $urandom_range(0, 7) == 0, eol);
   endtask

   task automatic put_fault(input fault_type fault, inout int last);
      int         len, addr, lo, pos, cnt;
      logic [7:0] c;
      logic [3:0] digits[8];
      case (fault)
         F_HEADER: begin
            push_char(CH_COLON);
            if ($urandom_range(0, 1) == 0) begin
               // line ends inside the header
               repeat ($urandom_range(0, 7)) push_nibble(4'($urandom_range(0, 15)));
            end else begin
               pos = $urandom_range(0, 7);
               for (int j = 0; j < 8; j++) digits[j] = 4'($urandom_range(0, 15));
               for (int j = 0; j < 8; j++) begin
                  if (j == pos) begin
                     do c = any_char();
                     while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                            (c >= 8'h61 && c <= 8'h66) || c == CH_CR);
                     push_char(c);
                  end else begin
                     push_nibble(digits[j]);
                  end
               end
               repeat ($urandom_range(0, 6)) push_nibble(4'($urandom_range(0, 15)));
            end
            push_eol();
         end
         F_SHORT: begin
            len = $urandom_range(0, 20);
            if (len > int'(limit_copy) - last) len = int'(limit_copy) - last;
            lo = int'(limit_copy) - len;
            addr = $urandom_range(last, (lo > 65535) ? 65535 : lo);
            // mostly the zero- and one-char bodies, which must not wrap
            cnt = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                              : $urandom_range(0, 2 * len + 1);
            put_record(len, addr, REC_DATA, cnt, 1'b0, 1'b1);
         end
         F_BACK, F_LIMIT: begin
            if (fault == F_BACK && last > 0) begin
               len  = $urandom_range(0, 8);
               addr = $urandom_range(0, last - 1);
            end else begin
               len = $urandom_range(2, 60);
               lo  = int'(limit_copy) - len + 1;
               if (lo < last) lo = last;
               addr = $urandom_range(lo, 65535);
            end
            put_record(len, addr, REC_DATA, 2 * len + 2, 1'b0, 1'b1);
         end
         F_TYPE: begin
            len = $urandom_range(0, 8);
            put_record(len, $urandom_range(0, 65535), 8'($urandom_range(2, 255)),
                       2 * len + 2, 1'b1, 1'b1);
         end
         F_FIRST, F_NOISE: begin
            c = any_char();
            if (fault == F_FIRST && (c == CH_HASH || c == CH_TYPE || c == CH_COLON))
               c = 8'h58;
            push_char(c);
            repeat ($urandom_range(0, 10)) push_char(any_char());
            push_eol();
         end
         F_EMPTY: push_eol();
         default: begin
            // comment near the length limit, on either side of it
            push_char(CH_HASH);
            repeat ($urandom_range(MAX_LINE - 3, MAX_LINE + 1)) begin
               do c = any_char(); while (c == CH_CR);
               push_char(c);
            end
            push_eol();
         end
      endcase
   endtask

   task automatic put_comment();
      push_char(CH_HASH);
      repeat ($urandom_range(0, 12)) push_char(any_char());
      push_eol();
   endtask

   task automatic put_type_line();
      push_char(CH_TYPE);
      repeat ($urandom_range(0, 8)) push_char(8'($urandom_range(8'h20, 8'h7E)));
      push_eol();
   endtask

   // One random file; a broken one carries a single fault somewhere
   task automatic put_file(input bit broken);
      fault_type fault;
      int        nrec, fault_at, last;
      fault = fault_type'($urandom_range(0, 9));
      nrec  = (broken && fault == F_NOTYPE) ? $urandom_range(0, 4) : $urandom_range(1, 6);
      fault_at = $urandom_range(0, (nrec > 0) ? nrec - 1 : 0);
      last = 0;
      if ($urandom_range(0, 2) == 0) put_comment();
      if (!(broken && fault == F_NOTYPE)) put_type_line();
      for (int i = 0; i < nrec; i++) begin
         if (broken && i == fault_at && fault != F_NOTYPE) put_fault(fault, last);
         else put_good_record(last, 1'b1);
         if ($urandom_range(0, 5) == 0) put_comment();
      end
      if ($urandom_range(0, 1) == 0) put_record(0, 0, REC_EOF, 2, 1'b0, 1'b1);
      // sometimes the file ends in the middle of an open line
      if ($urandom_range(0, 3) == 0) put_good_record(last, 1'b0);
      push_eof();
   endtask

   // Wait until all words are sent and every result is back
   task automatic wait_idle();
      do @(negedge clock);
      while (file_words.size() != 0 || req_ch.valid || expected_words.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_copy = v;
      limits_used++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus: directed files, then phases of random files per data_limit
   // ---------------------------------------------------------------------------
   initial begin
      int phase, start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty file: no type line
      push_eof();
      // record before any type line, closed by end of file
      push_char(CH_COLON);
      push_eof();
      // type line with CR, comment with 0xFF, header cut short, then dropped chars
      push_char(CH_TYPE);
      push_char(CH_CR);
      push_char(CH_LF);
      push_char(CH_HASH);
      push_char(8'hFF);
      push_char(CH_LF);
      push_char(CH_COLON);
      push_char(8'h30);
      push_char(CH_LF);
      push_char(8'h00);
      push_eof();
      // empty line
      push_char(CH_TYPE);
      push_char(CH_LF);
      push_char(CH_LF);
      push_eof();
      // unknown first char, line left open at end of file
      push_char(CH_TYPE);
      push_char(CH_LF);
      push_char(8'h00);
      push_eof();

      phase = 0;
      do begin
         if (phase > 0) begin
            case (phase)
               1:       write_limit(17'h10000);
               2:       write_limit('0);
               3:       write_limit(LIMIT_W'($urandom_range(1, 65535)));
               4:       write_limit(LIMIT_RESET);
               default: write_limit($urandom_range(0, 1) ? 17'h10000
                                                          : LIMIT_W'($urandom_range(1, 1024)));
            endcase
         end
         start = pushed_words;
         while (pushed_words - start < PHASE_SIZE) begin
            put_file($urandom_range(0, 3) == 0);
            // now and then hold the sender until the block has drained
            if ($urandom_range(0, 7) == 0) wait_idle();
         end
         wait_idle();
         phase++;
      end while (pushed_words < ITEM_GOAL);

      repeat (20) @(negedge clock);
      $display("covered %0d files under %0d data_limit settings, %0d words parsed",
               files_sent, limits_used, useful_words);
      $display("checked %0d data bytes, %0d line verdicts, %0d file verdicts, %0d errors",
               data_seen, line_seen, file_seen, error_count);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("intel_hex_stream_validator regression: pass");
      end else begin
         $display("intel_hex_stream_validator regression: fail");
      end
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", expected_words.size());
      $display("intel_hex_stream_validator regression: fail");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ihsv_pkg.sv
rtl/ihsv_req_if.sv
rtl/ihsv_rsp_if.sv
rtl/intel_hex_stream_validator.sv
sim/tb.sv
